[rtl/core/integer_string_parser_defines.svh]
// Assertion macros for the integer string parser checker.
`ifndef INTEGER_STRING_PARSER_DEFINES_SVH
`define INTEGER_STRING_PARSER_DEFINES_SVH

// Same-cycle implication.
`define IPS_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication.
`define IPS_ASSERT_NXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

[rtl/core/ips_pkg.sv]
package ips_pkg;

  localparam int POS_WIDTH_DEFAULT = 16;
  localparam int VALUE_WIDTH       = 64;
  localparam int OFFSET_WIDTH      = 16;

  localparam logic [5:0] BASE_MAX = 6'd36;
  localparam logic [5:0] BASE_MIN = 6'd2;
  localparam logic [5:0] BASE_8   = 6'd8;
  localparam logic [5:0] BASE_10  = 6'd10;
  localparam logic [5:0] BASE_16  = 6'd16;
  localparam logic [5:0] BASE_AUTO = 6'd0;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;

  localparam logic REG_RADIX       = 1'b0;
  localparam logic REG_SIGNED_MODE = 1'b1;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_LEAD   = 6'b000010,
    PH_SIGN   = 6'b000100,
    PH_ZERO   = 6'b001000,
    PH_XSEEN  = 6'b010000,
    PH_DIGITS = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [5:0] radix;
    logic       signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } item_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0]  value;
    logic [OFFSET_WIDTH-1:0] end_offset;
    logic                    found_digits;
    logic                    saturated;
    logic                    bad_base;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic [VALUE_WIDTH-1:0] acc;
    logic                   ovf;
  } mac_t;

  function automatic hex_t hex_of(input logic [7:0] c);
    hex_t       h;
    logic [7:0] t;
    h.valid = 1'b1;
    t = 8'd0;
    if (c >= CH_0 && c <= CH_9) begin
      t = c - CH_0;
    end else if (c >= CH_UA && c <= CH_UF) begin
      t = c - CH_UA + 8'd10;
    end else if (c >= CH_LA && c <= CH_LF) begin
      t = c - CH_LA + 8'd10;
    end else begin
      h.valid = 1'b0;
    end
    h.val = t[3:0];
    return h;
  endfunction

endpackage

[rtl/core/ips_in_stage.sv]
module ips_in_stage (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      ch,
  input  logic            first,
  input  logic            advance,
  output logic            item_valid,
  output ips_pkg::item_t  item
);

  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.ch    <= ch;
      item.first <= first;
    end
  end

endmodule

[rtl/core/ips_mac.sv]
module ips_mac (
  input  logic [ips_pkg::VALUE_WIDTH-1:0] acc,
  input  logic                            ovf,
  input  logic [5:0]                      base,
  input  logic [3:0]                      digit,
  input  logic                            signed_mode,
  input  logic                            negative,
  output ips_pkg::mac_t                   res
);

  localparam int VW = ips_pkg::VALUE_WIDTH;

  logic [VW+5:0] prod;
  logic [VW+6:0] sum;
  logic [VW+6:0] limit;
  logic          over;

  always_comb begin
    prod = (VW+6)'(acc) * (VW+6)'(base);
    sum  = (VW+7)'(prod) + (VW+7)'(digit);
    if (signed_mode) begin
      limit = (VW+7)'({1'b0, {(VW-1){1'b1}}}) + (VW+7)'(negative);
    end else begin
      limit = (VW+7)'({VW{1'b1}});
    end
    over = ovf || (sum > limit);
    res.ovf = over;
    res.acc = over ? acc : sum[VW-1:0];
  end

endmodule

[rtl/core/ips_core.sv]
module ips_core #(
  parameter int POS_WIDTH = ips_pkg::POS_WIDTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  ips_pkg::item_t   item,
  input  ips_pkg::cfg_t    cfg,
  output logic             advance,
  output logic             out_valid,
  input  logic             out_ready,
  output ips_pkg::result_t res
);

  localparam int VW = ips_pkg::VALUE_WIDTH;

  ips_pkg::phase_t        phase, ph_c, phase_next;
  logic                   negative, neg_c, negative_next;
  logic [5:0]             base_in_use, base_c, base_in_use_next;
  logic [VW-1:0]          accumulator, acc_c, accumulator_next;
  logic                   overflowed, ovf_c, overflowed_next;
  logic                   any_digit, any_c, any_digit_next;
  logic [POS_WIDTH-1:0]   position, pos_c, position_next;

  logic [5:0]             eff_base;
  ips_pkg::hex_t          hex;
  ips_pkg::mac_t          mac;
  ips_pkg::result_t       fin, r;
  logic                   fire, emit, take, lead_go, dig_go, any_f;
  logic                   bad_radix, zero_pref, digit_ok;

  assign advance = !out_valid || out_ready;
  assign fire    = item_valid && advance;

  always_comb begin
    ph_c   = item.first ? ips_pkg::PH_LEAD : phase;
    neg_c  = item.first ? 1'b0 : negative;
    base_c = item.first ? cfg.radix : base_in_use;
    acc_c  = item.first ? '0 : accumulator;
    ovf_c  = item.first ? 1'b0 : overflowed;
    any_c  = item.first ? 1'b0 : any_digit;
    pos_c  = item.first ? '0 : position;
  end

  assign hex = ips_pkg::hex_of(item.ch);

  always_comb begin
    case (ph_c) inside
      ips_pkg::PH_LEAD, ips_pkg::PH_SIGN:
        eff_base = (base_c == ips_pkg::BASE_AUTO) ? ips_pkg::BASE_10 : base_c;
      ips_pkg::PH_ZERO:
        eff_base = (base_c == ips_pkg::BASE_AUTO) ? ips_pkg::BASE_8 : base_c;
      ips_pkg::PH_XSEEN:
        eff_base = ips_pkg::BASE_16;
      default:
        eff_base = base_c;
    endcase
  end

  assign bad_radix = (base_c != ips_pkg::BASE_AUTO) &&
                     (base_c < ips_pkg::BASE_MIN || base_c > ips_pkg::BASE_MAX);
  assign zero_pref = (base_c == ips_pkg::BASE_AUTO || base_c == ips_pkg::BASE_16) &&
                     (item.ch == ips_pkg::CH_0);
  assign digit_ok  = hex.valid && ({2'b00, hex.val} < eff_base);

  ips_mac u_mac (
    .acc         (acc_c),
    .ovf         (ovf_c),
    .base        (eff_base),
    .digit       (hex.val),
    .signed_mode (cfg.signed_mode),
    .negative    (neg_c),
    .res         (mac)
  );

  // finish: result for the current digits
  always_comb begin
    any_f = any_c || (ph_c == ips_pkg::PH_ZERO);
    if (ovf_c) begin
      if (cfg.signed_mode) begin
        fin.value = neg_c ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}};
      end else begin
        fin.value = {VW{1'b1}};
      end
    end else begin
      fin.value = neg_c ? (~acc_c + VW'(1)) : acc_c;
    end
    fin.end_offset   = any_f ? ips_pkg::OFFSET_WIDTH'(pos_c) : '0;
    fin.found_digits = any_f;
    fin.saturated    = ovf_c;
    fin.bad_base     = 1'b0;
  end

  always_comb begin
    phase_next       = ph_c;
    negative_next    = neg_c;
    base_in_use_next = base_c;
    accumulator_next = acc_c;
    overflowed_next  = ovf_c;
    any_digit_next   = any_c;
    emit    = 1'b0;
    take    = 1'b0;
    lead_go = 1'b0;
    dig_go  = 1'b0;
    r       = fin;

    unique case (ph_c)
      ips_pkg::PH_IDLE: begin
      end
      ips_pkg::PH_LEAD: begin
        if (item.ch == ips_pkg::CH_SPACE) begin
        end else if (item.ch == ips_pkg::CH_MINUS) begin
          negative_next = 1'b1;
          phase_next    = ips_pkg::PH_SIGN;
        end else if (item.ch == ips_pkg::CH_PLUS) begin
          phase_next = ips_pkg::PH_SIGN;
        end else begin
          lead_go = 1'b1;
        end
      end
      ips_pkg::PH_SIGN: begin
        lead_go = 1'b1;
      end
      ips_pkg::PH_ZERO: begin
        if (item.ch == ips_pkg::CH_LX || item.ch == ips_pkg::CH_UX) begin
          phase_next = ips_pkg::PH_XSEEN;
        end else begin
          any_digit_next   = 1'b1;
          base_in_use_next = eff_base;
          phase_next       = ips_pkg::PH_DIGITS;
          dig_go           = 1'b1;
        end
      end
      ips_pkg::PH_XSEEN: begin
        if (hex.valid) begin
          base_in_use_next = ips_pkg::BASE_16;
          phase_next       = ips_pkg::PH_DIGITS;
          take             = 1'b1;
        end else begin
          emit             = 1'b1;
          phase_next       = ips_pkg::PH_IDLE;
          r.value          = '0;
          r.end_offset     = ips_pkg::OFFSET_WIDTH'(pos_c - POS_WIDTH'(1));
          r.found_digits   = 1'b1;
          r.saturated      = 1'b0;
          r.bad_base       = 1'b0;
        end
      end
      ips_pkg::PH_DIGITS: begin
        dig_go = 1'b1;
      end
      default: begin
      end
    endcase

    if (lead_go) begin
      if (bad_radix) begin
        emit           = 1'b1;
        phase_next     = ips_pkg::PH_IDLE;
        r.value        = '0;
        r.end_offset   = '0;
        r.found_digits = 1'b0;
        r.saturated    = 1'b0;
        r.bad_base     = 1'b1;
      end else if (zero_pref) begin
        phase_next = ips_pkg::PH_ZERO;
      end else begin
        base_in_use_next = eff_base;
        phase_next       = ips_pkg::PH_DIGITS;
        dig_go           = 1'b1;
      end
    end

    if (dig_go) begin
      if (digit_ok) begin
        take = 1'b1;
      end else begin
        emit       = 1'b1;
        phase_next = ips_pkg::PH_IDLE;
      end
    end

    if (take) begin
      accumulator_next = mac.acc;
      overflowed_next  = mac.ovf;
      any_digit_next   = 1'b1;
    end

    if (ph_c == ips_pkg::PH_IDLE || pos_c == {POS_WIDTH{1'b1}}) begin
      position_next = pos_c;
    end else begin
      position_next = pos_c + POS_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= ips_pkg::PH_IDLE;
    end else if (fire) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      negative    <= negative_next;
      base_in_use <= base_in_use_next;
      accumulator <= accumulator_next;
      overflowed  <= overflowed_next;
      any_digit   <= any_digit_next;
      position    <= position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res <= r;
    end
  end

endmodule

[rtl/core/integer_string_parser.sv]
// Streaming integer parser, one character per item.
// Input channel (in_valid/in_ready): ch and first. An item with first=1
// starts a new string at index 0; items outside a string are dropped.
// Output channel (out_valid/out_ready): value, end_offset, found_digits,
// saturated, bad_base. At most one result per string, at the first character
// that is not part of the number (byte 0 included).
// Configuration: wr_en/wr_index/wr_data write radix (index 0) and
// signed_mode (index 1); write only while no string is in flight.
// Throughput: one item per cycle unless a held result stalls it; the
// accumulate step (64x6 multiply-add and limit compare) feeds back into the
// accumulator combinationally. Path: an accepted item is held in the input
// register, and its result is then registered in the result register.
// Reset: synchronous; clears both channels, returns to idle, sets radix 0
// and signed_mode 1.
// Stall: while a result is held, one more item is taken into the input
// register; further items wait until out_ready frees the result register.
module integer_string_parser #(
  parameter int POS_WIDTH = ips_pkg::POS_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       ch,
  input  logic                             first,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ips_pkg::VALUE_WIDTH-1:0]  value,
  output logic [ips_pkg::OFFSET_WIDTH-1:0] end_offset,
  output logic                             found_digits,
  output logic                             saturated,
  output logic                             bad_base,
  input  logic                             wr_en,
  input  logic                             wr_index,
  input  logic [5:0]                       wr_data
);

  ips_pkg::cfg_t    cfg;
  ips_pkg::item_t   item;
  ips_pkg::result_t res;
  logic             item_valid;
  logic             advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.radix       <= ips_pkg::BASE_AUTO;
      cfg.signed_mode <= 1'b1;
    end else if (wr_en) begin
      case (wr_index)
        ips_pkg::REG_RADIX:       cfg.radix       <= wr_data;
        ips_pkg::REG_SIGNED_MODE: cfg.signed_mode <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

  ips_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .first      (first),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ips_core #(
    .POS_WIDTH (POS_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .res        (res)
  );

  assign value        = res.value;
  assign end_offset   = res.end_offset;
  assign found_digits = res.found_digits;
  assign saturated    = res.saturated;
  assign bad_base     = res.bad_base;

endmodule

[rtl/core/ips_checker.sv]
`include "integer_string_parser_defines.svh"

module ips_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [ips_pkg::VALUE_WIDTH-1:0]  value,
  input logic [ips_pkg::OFFSET_WIDTH-1:0] end_offset,
  input logic                             found_digits,
  input logic                             saturated,
  input logic                             bad_base
);

  `IPS_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(value) && $stable(end_offset), "stalled result changed")

  `IPS_ASSERT_IMP(a_bad_base, clk, rst, out_valid && bad_base, value == '0 && end_offset == '0 && !found_digits && !saturated, "bad base result not cleared")

  `IPS_ASSERT_IMP(a_no_digits, clk, rst, out_valid && !found_digits, end_offset == '0 && !saturated, "no-digit result has offset or saturation")

  `IPS_ASSERT_IMP(a_reset_quiet, clk, rst, $past(rst), !out_valid, "result valid right after reset")

  `IPS_ASSERT_IMP(a_in_stall, clk, rst, in_valid && !in_ready, out_valid && !out_ready, "input stalled without held result")

endmodule

bind integer_string_parser ips_checker u_ips_checker (.*);
